@@ sv/dedup_request_fifo_top_assert.svh @@
// assertion macros for the request queue
`ifndef DEDUP_REQUEST_FIFO_TOP_ASSERT_SVH
`define DEDUP_REQUEST_FIFO_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is high
`define DRQF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, active during reset as well
`define DRQF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DRQF_ASSERT(label, clk, rst, prop, msg)
`define DRQF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ sv/drqf_pkg.sv @@
// shared types and constants of the request queue
`timescale 1ns / 1ps
package drqf_pkg;

  localparam int FLOOR_W       = 4;
  localparam int DIR_W         = 2;
  localparam int STATUS_W      = 3;
  localparam int DEFAULT_DEPTH = 16;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                    load;
    logic                    shift;
    logic [FLOOR_W-1:0]      floor;
    logic signed [DIR_W-1:0] direction;
  } cell_cmd_t;

endpackage

@@ sv/drqf_if.sv @@
// request and result channel interfaces
`timescale 1ns / 1ps
interface drqf_req_if;
  import drqf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [FLOOR_W-1:0]      floor;
  logic signed [DIR_W-1:0] direction;
  modport source (output valid, operation, floor, direction, input ready);
  modport sink (input valid, operation, floor, direction, output ready);
endinterface

interface drqf_res_if;
  import drqf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [FLOOR_W-1:0]      popped_floor;
  logic signed [DIR_W-1:0] popped_direction;
  logic                    now_empty;
  modport source (output valid, status, popped_floor, popped_direction, now_empty,
                  input ready);
  modport sink (input valid, status, popped_floor, popped_direction, now_empty,
                output ready);
endinterface

@@ sv/drqf_cell.sv @@
// one queue cell: holds an entry, compares it, shifts toward the head
`timescale 1ns / 1ps
module drqf_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  drqf_pkg::cell_cmd_t              cmd,
  input  logic                             prev_valid,
  input  logic                             next_valid,
  input  logic [drqf_pkg::FLOOR_W-1:0]     next_floor,
  input  logic signed [drqf_pkg::DIR_W-1:0] next_direction,
  output logic                             valid,
  output logic [drqf_pkg::FLOOR_W-1:0]     floor,
  output logic signed [drqf_pkg::DIR_W-1:0] direction,
  output logic                             match
);
  import drqf_pkg::*;

  logic take;

  // first free cell behind the occupied prefix takes a new entry
  assign take = cmd.load && !valid && prev_valid;

  // duplicate compare against the pending request
  assign match = valid && (floor == cmd.floor) && (direction == cmd.direction);

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.shift) begin
      valid <= next_valid;
    end else if (take) begin
      valid <= 1'b1;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      floor     <= next_floor;
      direction <= next_direction;
    end else if (take) begin
      floor     <= cmd.floor;
      direction <= cmd.direction;
    end
  end

endmodule

@@ sv/dedup_request_fifo_top.sv @@
// Request queue with duplicate suppression, built as a chain of DEPTH cells.
// A request is captured into the request register, then evaluated in the evaluate step
// in which every cell compares, loads or shifts, and its result is registered; a result
// not yet taken holds that step. No new request is taken until that step is done.
// Reset: synchronous; valid bits of all cells clear together, no clear pass.
`timescale 1ns / 1ps
module dedup_request_fifo_top #(
  parameter int DEPTH = drqf_pkg::DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  drqf_req_if.sink    req,
  drqf_res_if.source  res
);
  import drqf_pkg::*;

  typedef enum logic {S_IDLE, S_EVAL} state_t;

  state_t                  state;
  logic                    req_op;
  logic [FLOOR_W-1:0]      req_floor;
  logic signed [DIR_W-1:0] req_direction;

  logic                    res_valid;
  status_t                 res_status;
  logic [FLOOR_W-1:0]      res_floor;
  logic signed [DIR_W-1:0] res_direction;
  logic                    res_empty;

  cell_cmd_t               cmd;
  logic [DEPTH-1:0]        valid_vec;
  logic [DEPTH-1:0]        match_vec;
  logic [FLOOR_W-1:0]      floor_arr [DEPTH];
  logic signed [DIR_W-1:0] dir_arr [DEPTH];

  logic                    commit;
  logic                    dup;
  logic                    full;
  status_t                 status_next;
  logic [FLOOR_W-1:0]      floor_next;
  logic signed [DIR_W-1:0] dir_next;
  logic                    empty_next;

  // cell chain, each cell fed by its tail-side neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    prev_v;
    logic                    next_v;
    logic [FLOOR_W-1:0]      next_f;
    logic signed [DIR_W-1:0] next_d;
    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = valid_vec[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_f = '0;
      assign next_d = '0;
    end else begin : g_link
      assign next_v = valid_vec[i+1];
      assign next_f = floor_arr[i+1];
      assign next_d = dir_arr[i+1];
    end
    drqf_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .cmd            (cmd),
      .prev_valid     (prev_v),
      .next_valid     (next_v),
      .next_floor     (next_f),
      .next_direction (next_d),
      .valid          (valid_vec[i]),
      .floor          (floor_arr[i]),
      .direction      (dir_arr[i]),
      .match          (match_vec[i])
    );
  end

  // queue status seen by the evaluate step
  assign dup    = |match_vec;
  assign full   = valid_vec[DEPTH-1];
  assign commit = (state == S_EVAL) && (!res_valid || res.ready);

  // cell command
  always_comb begin
    cmd.floor     = req_floor;
    cmd.direction = req_direction;
    cmd.load      = commit && (req_op == OP_INSERT) && !dup && !full;
    cmd.shift     = commit && (req_op == OP_POP) && valid_vec[0];
  end

  // result of the pending request
  always_comb begin
    floor_next = '0;
    dir_next   = '0;
    empty_next = 1'b0;
    case (req_op)
      OP_INSERT: begin
        if (dup) begin
          status_next = ST_DUPLICATE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_INSERTED;
        end
      end
      default: begin
        if (!valid_vec[0]) begin
          status_next = ST_EMPTY;
          empty_next  = 1'b1;
        end else begin
          status_next = ST_POPPED;
          floor_next  = floor_arr[0];
          dir_next    = dir_arr[0];
          empty_next  = !valid_vec[1];
        end
      end
    endcase
  end

  // state, request capture and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          // result transfer frees the output register
          if (res_valid && res.ready) begin
            res_valid <= 1'b0;
          end
          if (req.valid) begin
            req_op        <= req.operation;
            req_floor     <= req.floor;
            req_direction <= req.direction;
            state         <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (commit) begin
            res_valid     <= 1'b1;
            res_status    <= status_next;
            res_floor     <= floor_next;
            res_direction <= dir_next;
            res_empty     <= empty_next;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // channel ports
  assign req.ready            = (state == S_IDLE);
  assign res.valid            = res_valid;
  assign res.status           = res_status;
  assign res.popped_floor     = res_floor;
  assign res.popped_direction = res_direction;
  assign res.now_empty        = res_empty;

`include "dedup_request_fifo_top_assert.svh"

  // occupied cells always form a prefix from the head
  `DRQF_ASSERT(a_prefix, clk, rst, ({1'b0, valid_vec[DEPTH-1:1]} & ~valid_vec) == '0, "valid cells not contiguous")
  // cells hold still outside a committed step
  `DRQF_ASSERT(a_hold, clk, rst, !(cmd.load || cmd.shift) |=> $stable(valid_vec), "cells changed without command")
  // a successful insert adds exactly one entry
  `DRQF_ASSERT(a_grow, clk, rst, cmd.load |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1, "insert did not add one entry")
  // a pop on an empty queue reports empty
  `DRQF_ASSERT(a_pop_empty, clk, rst, commit && (req_op == OP_POP) && !valid_vec[0] |=> res_status == ST_EMPTY && res_empty, "empty pop misreported")
  // reset leaves no result pending and no cell occupied
  `DRQF_ASSERT_ALWAYS(a_rst, clk, rst |=> !res_valid && (valid_vec == '0), "reset left state behind")

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the request queue with duplicate suppression
`timescale 1ns / 1ps
module testbench;
  import drqf_pkg::*;

  localparam int QDEPTH           = 16;
  localparam int TOTAL_ITEMS      = 1775;
  localparam int PHASE1_AT        = 600;
  localparam int PHASE2_AT        = 1200;
  localparam int DRAIN_PAUSE_AT   = 900;
  localparam int LONG_HOLD_AT     = 1350;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 10;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int MAX_REPORTS      = 10;

  typedef struct {
    logic                    op;
    logic [FLOOR_W-1:0]      fl;
    logic signed [DIR_W-1:0] dir;
    bit                      wait_drain;
  } request_t;

  typedef struct {
    status_t                 status;
    logic [FLOOR_W-1:0]      fl;
    logic signed [DIR_W-1:0] dir;
    logic                    now_empty;
  } response_t;

  logic clk;
  logic rst;

  drqf_req_if req_ch ();
  drqf_res_if res_ch ();

  dedup_request_fifo_top #(.DEPTH(QDEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  request_t  pending_requests[$];
  response_t expected_responses[$];

  // queue contents as the block should hold them, oldest at index 0
  logic [FLOOR_W-1:0]      model_floor[QDEPTH];
  logic signed [DIR_W-1:0] model_dir[QDEPTH];
  int                      model_count;

  int        accepted_cnt;
  int        rcvd_cnt;
  int        mismatch_cnt;
  int        cycle_cnt;
  logic [1:0] idle_phase;
  logic      rx_hold;
  logic      hold_done;
  int        hold_left;
  response_t exp_r;
  request_t  next_rq;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // expected response for one accepted request, updates the queue contents
  function automatic response_t compute_response(request_t rq);
    response_t r;
    bit        dup;
    dup = 1'b0;
    r.status = ST_INSERTED;
    r.fl = '0;
    r.dir = '0;
    if (rq.op == OP_INSERT) begin
      for (int i = 0; i < model_count; i++) begin
        if (model_floor[i] == rq.fl && model_dir[i] == rq.dir) dup = 1'b1;
      end
      if (dup) begin
        r.status = ST_DUPLICATE;
      end else if (model_count >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        model_floor[model_count] = rq.fl;
        model_dir[model_count] = rq.dir;
        model_count++;
        r.status = ST_INSERTED;
      end
    end else if (model_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.fl = model_floor[0];
      r.dir = model_dir[0];
      for (int i = 0; i + 1 < model_count; i++) begin
        model_floor[i] = model_floor[i + 1];
        model_dir[i] = model_dir[i + 1];
      end
      model_count--;
      r.status = ST_POPPED;
    end
    r.now_empty = (model_count == 0);
    return r;
  endfunction

  function automatic void push_request(logic op, int fl, int dir, bit wait_drain);
    request_t rq;
    rq.op = op;
    rq.fl = fl[FLOOR_W-1:0];
    rq.dir = dir[DIR_W-1:0];
    rq.wait_drain = wait_drain;
    pending_requests.push_back(rq);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      accepted_cnt <= 0;
      idle_phase <= 2'd0;
      model_count = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_responses.push_back(compute_response(next_rq));
        accepted_cnt <= accepted_cnt + 1;
      end
      idle_phase <= (accepted_cnt < PHASE1_AT) ? 2'd0 :
                    (accepted_cnt < PHASE2_AT) ? 2'd1 : 2'd2;
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_requests.size() == 0) begin
          req_ch.valid <= 1'b0;
        end else if (pending_requests[0].wait_drain &&
                     (req_ch.valid || accepted_cnt != rcvd_cnt)) begin
          // hold off until every response is back
          req_ch.valid <= 1'b0;
        end else if ((idle_phase == 2'd0 && $urandom_range(0, 99) < 9) ||
                     (idle_phase == 2'd1 && $urandom_range(0, 99) < 84)) begin
          req_ch.valid <= 1'b0;
        end else begin
          next_rq = pending_requests.pop_front();
          req_ch.operation <= next_rq.op;
          req_ch.floor <= next_rq.fl;
          req_ch.direction <= next_rq.dir;
          req_ch.valid <= 1'b1;
        end
      end
    end
  end

  // long receiver hold so the queue backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      rx_hold <= 1'b0;
      hold_done <= 1'b0;
      hold_left <= 0;
    end else if (!hold_done && accepted_cnt >= LONG_HOLD_AT) begin
      rx_hold <= 1'b1;
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
    end else if (hold_left > 0) begin
      rx_hold <= (hold_left > 1);
      hold_left <= hold_left - 1;
    end
  end

  // response monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rcvd_cnt <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        rcvd_cnt <= rcvd_cnt + 1;
        if (expected_responses.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("cycle %0d: response with none expected, status %0d", cycle_cnt,
                     res_ch.status);
        end else begin
          exp_r = expected_responses.pop_front();
          if (res_ch.status !== exp_r.status || res_ch.popped_floor !== exp_r.fl ||
              res_ch.popped_direction !== exp_r.dir || res_ch.now_empty !== exp_r.now_empty)
          begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display({"cycle %0d: expected status %0d floor %0d dir %0d empty %0b,",
                        " got status %0d floor %0d dir %0d empty %0b"},
                       cycle_cnt, exp_r.status, exp_r.fl, exp_r.dir, exp_r.now_empty,
                       res_ch.status, res_ch.popped_floor, res_ch.popped_direction,
                       res_ch.now_empty);
          end
        end
      end
      res_ch.ready <= !rx_hold &&
                      !((idle_phase == 2'd0 && $urandom_range(0, 99) < 84) ||
                        (idle_phase == 2'd1 && $urandom_range(0, 99) < 9));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int  mode;
    int  burst_len;
    int  ins_pct;
    bit  narrow;
    int  fl;
    clk = 1'b0;
    rst = 1'b1;
    cycle_cnt = 0;
    mismatch_cnt = 0;
    rcvd_cnt = 0;
    accepted_cnt = 0;
    rx_hold = 1'b0;
    idle_phase = 2'd0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_INSERT;
    req_ch.floor = '0;
    req_ch.direction = '0;
    res_ch.ready = 1'b0;

    // directed: pop on empty, fill with extremes, duplicate, full, duplicate into full
    push_request(OP_POP, 0, 0, 1'b0);
    for (int i = 0; i < QDEPTH; i++) begin
      push_request(OP_INSERT, i, i % 4, 1'b0);
      if (i == 1) push_request(OP_INSERT, 0, 0, 1'b0);
    end
    push_request(OP_INSERT, 3, 0, 1'b0);
    push_request(OP_INSERT, 15, 3, 1'b0);
    push_request(OP_POP, 15, 3, 1'b0);
    push_request(OP_POP, 0, 0, 1'b0);
    push_request(OP_INSERT, 15, 1, 1'b0);

    // random bursts: fill-heavy, drain-heavy or balanced, narrow or wide values
    while (pending_requests.size() < TOTAL_ITEMS) begin
      mode = $urandom_range(0, 2);
      burst_len = $urandom_range(4, 40);
      narrow = $urandom_range(0, 1);
      ins_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      for (int k = 0; k < burst_len; k++) begin
        fl = narrow ? $urandom_range(0, 3) : $urandom_range(0, 15);
        push_request(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP, fl,
                     $urandom_range(0, 3), 1'b0);
      end
    end
    pending_requests[23].wait_drain = 1'b1;
    pending_requests[DRAIN_PAUSE_AT].wait_drain = 1'b1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || accepted_cnt != rcvd_cnt)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && expected_responses.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/drqf_pkg.sv
sv/drqf_if.sv
sv/drqf_cell.sv
sv/dedup_request_fifo_top.sv
tb/testbench.sv
